// ===== rtl/fitp_pkg.sv =====
// Shared types, constants and character functions for the file id token parser.
// No dependencies; imported by file_id_token_parser.
package fitp_pkg;

  localparam int MAX_PARTS_DEF      = 255;
  localparam int MAX_PART_CHARS_DEF = 255;

  localparam logic [7:0] CH_BLANK   = 8'h40;
  localparam logic [7:0] CH_DOT     = 8'h4B;
  localparam logic [7:0] CH_EQUAL   = 8'h7E;
  localparam logic [7:0] CH_UPPER_A = 8'hC1;

  typedef enum logic [1:0] {
    PH_START,
    PH_SKIP,
    PH_TOKEN,
    PH_SEP
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK,
    ST_NONE,
    ST_INCOMPLETE,
    ST_TOOLONG,
    ST_TOOMANY,
    ST_NODEFAULTS
  } status_t;

  typedef enum logic [1:0] {
    TERM_END,
    TERM_BLANK,
    TERM_DOT
  } term_t;

  typedef enum logic [1:0] {
    FN_CHAR,
    FN_END_PART,
    FN_END_LIST,
    FN_UNUSED
  } func_t;

  typedef enum logic [1:0] {
    REG_NAME,
    REG_TYPE,
    REG_MODE,
    REG_PRESENT
  } reg_idx_t;

  typedef struct packed {
    logic [63:0] chars;
    logic [3:0]  len;
  } dflt8_t;

  typedef struct packed {
    logic [15:0] chars;
    logic [1:0]  len;
  } dflt2_t;

  function automatic logic [7:0] ebcdic_upper(logic [7:0] c);
    logic [7:0] u;
    case (c) inside
      [8'h42:8'h49], [8'h51:8'h58], [8'hCB:8'hCF], [8'hDB:8'hDE]: u = c + 8'h20;
      [8'h81:8'h89], [8'h91:8'h99], [8'hA2:8'hA9]:                 u = c + 8'h40;
      8'h70:   u = 8'h80;
      8'h8C:   u = 8'hAC;
      8'h8D:   u = 8'hBA;
      8'h9C:   u = 8'h9E;
      8'hAE:   u = 8'h8E;
      default: u = c;
    endcase
    return u;
  endfunction

  // take bytes from the top until a zero byte, upper-cased
  function automatic dflt8_t load_dflt8(logic [63:0] src);
    dflt8_t r;
    logic   alive;
    r     = '0;
    alive = 1'b1;
    for (int i = 0; i < 8; i++) begin
      if (src[63-8*i -: 8] == 8'h00) alive = 1'b0;
      if (alive) begin
        r.chars[63-8*i -: 8] = ebcdic_upper(src[63-8*i -: 8]);
        r.len                = r.len + 4'd1;
      end
    end
    return r;
  endfunction

  function automatic dflt2_t load_dflt2(logic [15:0] src);
    dflt2_t r;
    logic   alive;
    r     = '0;
    alive = 1'b1;
    for (int i = 0; i < 2; i++) begin
      if (src[15-8*i -: 8] == 8'h00) alive = 1'b0;
      if (alive) begin
        r.chars[15-8*i -: 8] = ebcdic_upper(src[15-8*i -: 8]);
        r.len                = r.len + 2'd1;
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/file_id_token_parser.sv =====
// File id token parser: input register, one pass of parse logic, result register.
// A beat accepted into the input register is parsed from there; any result beat it
// ends is registered. Throughput: one beat per cycle, limited only by out_tready.
// Reset (rst_n low, synchronous): parse state, defaults and both valid flags clear.
// Depends on fitp_pkg.
module file_id_token_parser #(
  parameter int MAX_PARTS      = fitp_pkg::MAX_PARTS_DEF,
  parameter int MAX_PART_CHARS = fitp_pkg::MAX_PART_CHARS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,    // [7:0] ch
  input  logic [1:0]   in_tuser,    // [1:0] func
  output logic         out_tvalid,
  input  logic         out_tready,
  // [63:0] name_chars, [127:64] type_chars, [143:128] mode_chars, [147:144] name_len,
  // [151:148] type_len, [153:152] mode_len, [161:154] parts_used, [169:162] stop_offset
  output logic [175:0] out_tdata,
  output logic [2:0]   out_tuser,   // [2:0] status
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [4:0]   cfg_paddr,
  input  logic [63:0]  cfg_pwdata,
  output logic [63:0]  cfg_prdata,
  output logic         cfg_pready
);
  import fitp_pkg::*;

  localparam logic [7:0] PART_LIM = 8'((MAX_PARTS < 255) ? MAX_PARTS : 255);
  localparam logic [7:0] CHAR_LIM = 8'((MAX_PART_CHARS < 255) ? MAX_PART_CHARS : 255);

  // configuration
  logic [63:0] dflt_name_r, dflt_type_r;
  logic [15:0] dflt_mode_r;
  logic [2:0]  dflt_present_r;
  reg_idx_t    cfg_idx;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[4:3]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dflt_name_r    <= '0;
      dflt_type_r    <= '0;
      dflt_mode_r    <= '0;
      dflt_present_r <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_NAME:    dflt_name_r    <= cfg_pwdata;
        REG_TYPE:    dflt_type_r    <= cfg_pwdata;
        REG_MODE:    dflt_mode_r    <= cfg_pwdata[15:0];
        REG_PRESENT: dflt_present_r <= cfg_pwdata[2:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_NAME:    cfg_prdata = dflt_name_r;
      REG_TYPE:    cfg_prdata = dflt_type_r;
      REG_MODE:    cfg_prdata = {48'd0, dflt_mode_r};
      REG_PRESENT: cfg_prdata = {61'd0, dflt_present_r};
    endcase
  end

  dflt8_t dn, dt;
  dflt2_t dm;
  assign dn = load_dflt8(dflt_name_r);
  assign dt = load_dflt8(dflt_type_r);
  assign dm = load_dflt2(dflt_mode_r);

  // input register
  logic       in_valid_r;
  logic [7:0] ch_r;
  func_t      func_r;
  logic       adv;

  assign adv       = in_valid_r && (!out_tvalid || out_tready);
  assign in_tready = !in_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      ch_r   <= in_tdata;
      func_r <= func_t'(in_tuser);
    end
  end

  // parse state
  phase_t      phase_r, phase_nxt;
  logic [1:0]  cc_r, cc_nxt;
  logic [3:0]  tl_r, tl_nxt;
  logic [63:0] name_r, name_nxt, type_r, type_nxt;
  logic [15:0] mode_r, mode_nxt;
  logic [3:0]  len0_r, len0_nxt, len1_r, len1_nxt;
  logic [1:0]  len2_r, len2_nxt;
  logic [7:0]  parts_r, parts_nxt, off_r, off_nxt;
  logic        fin_r, fin_nxt;

  // pass results
  logic        emit;
  status_t     st;
  logic        do_start, do_tok, do_end, is_eq;
  term_t       term;
  logic [1:0]  idx;
  logic [7:0]  upc;
  logic [63:0] res_name, res_type;
  logic [15:0] res_mode;
  logic [3:0]  res_len0, res_len1;
  logic [1:0]  res_len2;
  logic [7:0]  res_parts, res_off;

  assign upc = ebcdic_upper(ch_r);

  always_comb begin
    phase_nxt = phase_r;
    cc_nxt    = cc_r;
    tl_nxt    = tl_r;
    name_nxt  = name_r;
    type_nxt  = type_r;
    mode_nxt  = mode_r;
    len0_nxt  = len0_r;
    len1_nxt  = len1_r;
    len2_nxt  = len2_r;
    parts_nxt = parts_r;
    off_nxt   = off_r;
    fin_nxt   = fin_r;
    emit      = 1'b0;
    st        = ST_OK;
    do_start  = 1'b0;
    do_tok    = 1'b0;
    do_end    = 1'b0;
    is_eq     = 1'b0;
    term      = TERM_END;
    idx       = 2'd0;

    if (!fin_r && func_r != FN_UNUSED) begin
      if (func_r == FN_CHAR) begin
        if (phase_nxt == PH_START) begin
          if (parts_nxt < PART_LIM) parts_nxt = parts_nxt + 8'd1;
          off_nxt   = 8'd0;
          phase_nxt = PH_SKIP;
        end
        case (phase_nxt)
          PH_SKIP: begin
            if (ch_r != CH_BLANK) begin
              do_start = 1'b1;
              if (ch_r == CH_DOT) begin
                do_end = 1'b1;
                term   = TERM_DOT;
              end else begin
                do_tok = 1'b1;
              end
            end
          end
          PH_TOKEN: begin
            if (ch_r == CH_BLANK) begin
              do_end = 1'b1;
              term   = TERM_BLANK;
            end else if (ch_r == CH_DOT) begin
              do_end = 1'b1;
              term   = TERM_DOT;
            end else begin
              do_tok = 1'b1;
            end
          end
          default: begin
            if (ch_r == CH_DOT) begin
              emit = 1'b1;
              st   = ST_INCOMPLETE;
            end else if (ch_r == CH_BLANK) begin
              phase_nxt = PH_SKIP;
            end else begin
              do_start = 1'b1;
              do_tok   = 1'b1;
            end
          end
        endcase
      end else begin
        case (phase_nxt)
          PH_START: begin
            if (func_r == FN_END_PART) begin
              if (parts_nxt < PART_LIM) parts_nxt = parts_nxt + 8'd1;
              off_nxt = 8'd0;
            end
          end
          PH_SKIP:  phase_nxt = PH_START;
          PH_TOKEN: do_end = 1'b1;
          default: begin
            emit = 1'b1;
            st   = ST_INCOMPLETE;
          end
        endcase
      end

      if (do_start) begin
        if (cc_nxt != 2'd3) cc_nxt = cc_nxt + 2'd1;
        idx = cc_nxt - 2'd1;
        case (idx)
          2'd0: begin
            name_nxt = '0;
            len0_nxt = '0;
          end
          2'd1: begin
            type_nxt = '0;
            len1_nxt = '0;
          end
          default: begin
            mode_nxt = '0;
            len2_nxt = '0;
          end
        endcase
        tl_nxt    = 4'd0;
        phase_nxt = PH_TOKEN;
      end

      idx = (cc_nxt == 2'd0) ? 2'd0 : cc_nxt - 2'd1;

      if (do_tok) begin
        if ((idx != 2'd2) ? (tl_nxt >= 4'd8) : (tl_nxt >= 4'd2)) begin
          emit = 1'b1;
          st   = ST_TOOLONG;
        end else begin
          case (idx)
            2'd0:    name_nxt[{3'd7 - tl_nxt[2:0], 3'b000} +: 8] = upc;
            2'd1:    type_nxt[{3'd7 - tl_nxt[2:0], 3'b000} +: 8] = upc;
            default: mode_nxt[{~tl_nxt[0], 3'b000} +: 8]         = upc;
          endcase
          tl_nxt = tl_nxt + 4'd1;
          case (idx)
            2'd0:    len0_nxt = tl_nxt;
            2'd1:    len1_nxt = tl_nxt;
            default: len2_nxt = tl_nxt[1:0];
          endcase
        end
      end

      if (do_end) begin
        if (term == TERM_DOT && cc_nxt == 2'd3) begin
          emit = 1'b1;
          st   = ST_TOOMANY;
        end else begin
          case (idx)
            2'd0:    is_eq = (len0_nxt == 4'd1) && (name_nxt[63:56] == CH_EQUAL);
            2'd1:    is_eq = (len1_nxt == 4'd1) && (type_nxt[63:56] == CH_EQUAL);
            default: is_eq = (len2_nxt == 2'd1) && (mode_nxt[15:8] == CH_EQUAL);
          endcase
          if (is_eq && !dflt_present_r[idx]) begin
            emit = 1'b1;
            st   = ST_NODEFAULTS;
          end else begin
            if (is_eq) begin
              case (idx)
                2'd0: begin
                  name_nxt = dn.chars;
                  len0_nxt = dn.len;
                end
                2'd1: begin
                  type_nxt = dt.chars;
                  len1_nxt = dt.len;
                end
                default: begin
                  mode_nxt = dm.chars;
                  len2_nxt = dm.len;
                end
              endcase
            end
            if (cc_nxt == 2'd3) begin
              emit = 1'b1;
              st   = ST_OK;
            end else begin
              phase_nxt = (term == TERM_END) ? PH_START : PH_SEP;
            end
          end
        end
      end

      if (func_r == FN_END_LIST && !emit) begin
        emit = 1'b1;
        if (cc_nxt == 2'd0) begin
          st = ST_NONE;
        end else if (cc_nxt == 2'd1 && !dflt_present_r[1]) begin
          st = ST_INCOMPLETE;
        end else begin
          st = ST_OK;
          if (cc_nxt == 2'd1) begin
            type_nxt = dt.chars;
            len1_nxt = dt.len;
            cc_nxt   = 2'd2;
          end
          if (cc_nxt == 2'd2) begin
            if (dflt_present_r[2]) begin
              mode_nxt = dm.chars;
              len2_nxt = dm.len;
            end else begin
              mode_nxt = {CH_UPPER_A, 8'h00};
              len2_nxt = 2'd1;
            end
          end
        end
      end

      if (func_r == FN_CHAR && !emit && off_nxt < CHAR_LIM) off_nxt = off_nxt + 8'd1;
      if (emit) fin_nxt = 1'b1;
    end

    res_name  = name_nxt;
    res_type  = type_nxt;
    res_mode  = mode_nxt;
    res_len0  = len0_nxt;
    res_len1  = len1_nxt;
    res_len2  = len2_nxt;
    res_parts = parts_nxt;
    res_off   = off_nxt;

    if (func_r == FN_END_LIST) begin
      phase_nxt = PH_START;
      cc_nxt    = '0;
      tl_nxt    = '0;
      name_nxt  = '0;
      type_nxt  = '0;
      mode_nxt  = '0;
      len0_nxt  = '0;
      len1_nxt  = '0;
      len2_nxt  = '0;
      parts_nxt = '0;
      off_nxt   = '0;
      fin_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      cc_r    <= '0;
      tl_r    <= '0;
      name_r  <= '0;
      type_r  <= '0;
      mode_r  <= '0;
      len0_r  <= '0;
      len1_r  <= '0;
      len2_r  <= '0;
      parts_r <= '0;
      off_r   <= '0;
      fin_r   <= 1'b0;
    end else if (adv) begin
      phase_r <= phase_nxt;
      cc_r    <= cc_nxt;
      tl_r    <= tl_nxt;
      name_r  <= name_nxt;
      type_r  <= type_nxt;
      mode_r  <= mode_nxt;
      len0_r  <= len0_nxt;
      len1_r  <= len1_nxt;
      len2_r  <= len2_nxt;
      parts_r <= parts_nxt;
      off_r   <= off_nxt;
      fin_r   <= fin_nxt;
    end
  end

  // result register
  logic out_valid_r;

  assign out_tvalid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && emit) begin
      out_tuser <= st;
      out_tdata <= {6'd0, res_off, res_parts, res_len2, res_len1, res_len0,
                    res_mode, res_type, res_name};
    end
  end

endmodule
